// ===== rtl/hcpf_pkg.sv =====
package hcpf_pkg;

   localparam int KEY_SLOT_COUNT = 6;

   // Longest payload: keyboard report or smooth move
   localparam int KB_PAY_LEN  = 2 + KEY_SLOT_COUNT;
   localparam int PAY_MAX     = (KB_PAY_LEN > 6) ? KB_PAY_LEN : 6;
   localparam int LEN_W       = $clog2(PAY_MAX + 1);
   // frame = 5 leading bytes + payload + checksum
   localparam int IDX_W       = $clog2(PAY_MAX + 6);
   localparam int PIDX_W      = $clog2(PAY_MAX);
   localparam int FRAME_LEAD  = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CFG_IDX_W   = 3;
   localparam int CFG_DATA_W  = 8;

   typedef enum logic [3:0] {
      FUNC_MOVE        = 4'd0,
      FUNC_SMOOTH_MOVE = 4'd1,
      FUNC_BTN_PRESS   = 4'd2,
      FUNC_BTN_RELEASE = 4'd3,
      FUNC_SCROLL      = 4'd4,
      FUNC_KEY_PRESS   = 4'd5,
      FUNC_KEY_RELEASE = 4'd6,
      FUNC_CLEAR_MODS  = 4'd7,
      FUNC_RELEASE_ALL = 4'd8
   } func_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_HEADER_FIRST     = 3'd0,
      CFG_HEADER_SECOND    = 3'd1,
      CFG_CODE_MOVE        = 3'd2,
      CFG_CODE_SMOOTH_MOVE = 3'd3,
      CFG_CODE_BUTTONS     = 3'd4,
      CFG_CODE_WHEEL       = 3'd5,
      CFG_CODE_KEYBOARD    = 3'd6,
      CFG_CODE_RELEASE_ALL = 3'd7
   } cfg_index_type;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] code_move;
      logic [7:0] code_smooth_move;
      logic [7:0] code_buttons;
      logic [7:0] code_wheel;
      logic [7:0] code_keyboard;
      logic [7:0] code_release_all;
   } cfg_type;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic [15:0]        move_time;
      logic signed [31:0] scroll_amount;
      logic [7:0]         button_bits;
      logic [7:0]         key_code;
      logic [7:0]         modifier_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } rsp_type;

   // One classified request, ready to serialise
   typedef struct packed {
      logic [7:0]               code;
      logic [LEN_W-1:0]         len;
      logic [PAY_MAX-1:0][7:0]  payload;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_req_type;

endpackage

// ===== rtl/hcpf_front.sv =====
module hcpf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  hcpf_pkg::cfg_type      cfg,
   input  hcpf_pkg::req_type      req_data,
   input  logic                   accept,
   output hcpf_pkg::frame_req_type frame_out
);

   logic [hcpf_pkg::KEY_SLOT_COUNT-1:0][7:0] slots_ff, slots_in;
   logic [7:0] mods_ff, mods_in;
   logic [7:0] btn_ff, btn_in;
   logic       held, placed, hit, kb_report;
   logic [15:0] dx, dy;
   logic [7:0]  wheel;

   function automatic logic [15:0] sat16(input logic signed [31:0] v);
      logic [15:0] r;
      if (v < -32'sd32768) begin
         r = 16'h8000;
      end else if (v > 32'sd32767) begin
         r = 16'h7FFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] sat8(input logic signed [31:0] v);
      logic [7:0] r;
      if (v < -32'sd127) begin
         r = 8'h81;
      end else if (v > 32'sd127) begin
         r = 8'h7F;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   assign dx    = sat16(req_data.delta_x);
   assign dy    = sat16(req_data.delta_y);
   assign wheel = sat8(req_data.scroll_amount);

   always_comb begin
      slots_in  = slots_ff;
      mods_in   = mods_ff;
      btn_in    = btn_ff;
      held      = 1'b0;
      placed    = 1'b0;
      hit       = 1'b0;
      kb_report = 1'b0;
      frame_out = '0;
      case (req_data.func)
         hcpf_pkg::FUNC_MOVE, hcpf_pkg::FUNC_SMOOTH_MOVE: begin
            frame_out.valid = 1'b1;
            frame_out.frame.payload[0] = dx[7:0];
            frame_out.frame.payload[1] = dx[15:8];
            frame_out.frame.payload[2] = dy[7:0];
            frame_out.frame.payload[3] = dy[15:8];
            if (req_data.func == hcpf_pkg::FUNC_MOVE) begin
               frame_out.frame.code = cfg.code_move;
               frame_out.frame.len  = hcpf_pkg::LEN_W'(4);
            end else begin
               frame_out.frame.code = cfg.code_smooth_move;
               frame_out.frame.len  = hcpf_pkg::LEN_W'(6);
               frame_out.frame.payload[4] = req_data.move_time[7:0];
               frame_out.frame.payload[5] = req_data.move_time[15:8];
            end
         end
         hcpf_pkg::FUNC_BTN_PRESS, hcpf_pkg::FUNC_BTN_RELEASE: begin
            if (req_data.func == hcpf_pkg::FUNC_BTN_PRESS) begin
               btn_in = btn_ff | req_data.button_bits;
            end else begin
               btn_in = btn_ff & ~req_data.button_bits;
            end
            frame_out.valid            = 1'b1;
            frame_out.frame.code       = cfg.code_buttons;
            frame_out.frame.len        = hcpf_pkg::LEN_W'(1);
            frame_out.frame.payload[0] = btn_in;
         end
         hcpf_pkg::FUNC_SCROLL: begin
            frame_out.valid            = 1'b1;
            frame_out.frame.code       = cfg.code_wheel;
            frame_out.frame.len        = hcpf_pkg::LEN_W'(1);
            frame_out.frame.payload[0] = wheel;
         end
         hcpf_pkg::FUNC_KEY_PRESS: begin
            mods_in = mods_ff | req_data.modifier_bits;
            for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
               if (slots_ff[i] == req_data.key_code) begin
                  held = 1'b1;
               end
            end
            // first empty slot takes a new key; a zero code counts as held
            for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
               if (!held && !placed && slots_ff[i] == 8'h00) begin
                  slots_in[i] = req_data.key_code;
                  placed      = 1'b1;
               end
            end
            kb_report = 1'b1;
         end
         hcpf_pkg::FUNC_KEY_RELEASE: begin
            for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
               if (!hit && slots_ff[i] == req_data.key_code) begin
                  slots_in[i] = 8'h00;
                  hit         = 1'b1;
               end
            end
            kb_report = 1'b1;
         end
         hcpf_pkg::FUNC_CLEAR_MODS: begin
            mods_in   = mods_ff & ~req_data.modifier_bits;
            kb_report = 1'b1;
         end
         hcpf_pkg::FUNC_RELEASE_ALL: begin
            mods_in              = 8'h00;
            slots_in             = '0;
            frame_out.valid      = 1'b1;
            frame_out.frame.code = cfg.code_release_all;
            frame_out.frame.len  = '0;
         end
         default: begin
            // unknown request: no frame, no state change
         end
      endcase
      if (kb_report) begin
         frame_out.valid            = 1'b1;
         frame_out.frame.code       = cfg.code_keyboard;
         frame_out.frame.len        = hcpf_pkg::LEN_W'(hcpf_pkg::KB_PAY_LEN);
         frame_out.frame.payload[0] = mods_in;
         frame_out.frame.payload[1] = 8'h00;
         for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
            frame_out.frame.payload[2+i] = slots_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
         mods_ff  <= '0;
         btn_ff   <= '0;
      end else if (accept) begin
         slots_ff <= slots_in;
         mods_ff  <= mods_in;
         btn_ff   <= btn_in;
      end
   end

endmodule

// ===== rtl/hcpf_queue.sv =====
module hcpf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hcpf_pkg::frame_type     push_frame,
   output logic                    full,
   output hcpf_pkg::frame_req_type head,
   input  logic                    pop
);

   hcpf_pkg::frame_type entry_ff [hcpf_pkg::QUEUE_DEPTH];
   logic [hcpf_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hcpf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == hcpf_pkg::QCNT_W'(hcpf_pkg::QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.frame = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == hcpf_pkg::QPTR_W'(hcpf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == hcpf_pkg::QPTR_W'(hcpf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/hcpf_back.sv =====
module hcpf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  hcpf_pkg::cfg_type       cfg,
   input  hcpf_pkg::frame_req_type head,
   output logic                    head_pop,
   output logic                    rsp_empty,
   output hcpf_pkg::rsp_type       rsp_data,
   input  logic                    rsp_pop
);

   localparam logic [hcpf_pkg::IDX_W-1:0] POS_HDR1   = hcpf_pkg::IDX_W'(0);
   localparam logic [hcpf_pkg::IDX_W-1:0] POS_HDR2   = hcpf_pkg::IDX_W'(1);
   localparam logic [hcpf_pkg::IDX_W-1:0] POS_CODE   = hcpf_pkg::IDX_W'(2);
   localparam logic [hcpf_pkg::IDX_W-1:0] POS_LEN_LO = hcpf_pkg::IDX_W'(3);
   localparam logic [hcpf_pkg::IDX_W-1:0] POS_LEN_HI = hcpf_pkg::IDX_W'(4);

   logic [hcpf_pkg::IDX_W-1:0]  idx_ff, idx_in, last_idx, pay_off;
   logic [hcpf_pkg::PIDX_W-1:0] pidx;
   logic [7:0]  sum_ff, sum_in, cur_byte;
   logic [15:0] len16;
   logic        out_valid_ff, advance, is_last, send;
   hcpf_pkg::rsp_type out_ff, out_in;

   assign len16    = 16'(head.frame.len);
   assign last_idx = hcpf_pkg::IDX_W'(hcpf_pkg::FRAME_LEAD) + hcpf_pkg::IDX_W'(head.frame.len);
   assign pay_off  = idx_ff - hcpf_pkg::IDX_W'(hcpf_pkg::FRAME_LEAD);
   assign pidx     = pay_off[hcpf_pkg::PIDX_W-1:0];
   assign is_last  = (idx_ff == last_idx);
   assign advance  = !out_valid_ff || rsp_pop;
   assign send     = advance && head.valid;
   assign head_pop = send && is_last;

   always_comb begin
      case (idx_ff)
         POS_HDR1:   cur_byte = cfg.header_first;
         POS_HDR2:   cur_byte = cfg.header_second;
         POS_CODE:   cur_byte = head.frame.code;
         POS_LEN_LO: cur_byte = len16[7:0];
         POS_LEN_HI: cur_byte = len16[15:8];
         default:    cur_byte = is_last ? sum_ff : head.frame.payload[pidx];
      endcase
   end

   always_comb begin
      sum_in = (idx_ff == POS_HDR1) ? cur_byte : sum_ff + cur_byte;
      idx_in = is_last ? '0 : idx_ff + 1'b1;
      out_in.packet_byte = cur_byte;
      out_in.last_byte   = is_last;
   end

   always_ff @(posedge clock) begin
      if (send) begin
         out_ff <= out_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (send) begin
         out_valid_ff <= 1'b1;
         idx_ff       <= idx_in;
      end else if (advance) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/hid_command_packet_framer.sv =====
// channel   ports                              direction  moves
// request   req_push, req_full, req_data       in         one input event
// response  rsp_pop, rsp_empty, rsp_data       out        one packet byte
// csr       csr_we, csr_index, csr_wdata       in         header/code register write
//
// Each request yields one frame of 6 to 14 bytes (none for an unknown func),
// delivered one byte per cycle while rsp_pop keeps taking bytes. Request decode and
// key/button state update take the accept cycle; the frame enters the queue at the
// accepting edge, then each byte is registered on rsp_data. A two-entry frame queue
// lets the front accept the next request while a frame is being sent. Synchronous
// active-high reset clears state, queue and output valid flag; a stalled rsp_pop
// holds the byte in place and back-pressures via req_full.
module hid_command_packet_framer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  hcpf_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output hcpf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [hcpf_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [hcpf_pkg::CFG_DATA_W-1:0]      csr_wdata
);

   hcpf_pkg::cfg_type       cfg_ff;
   hcpf_pkg::frame_req_type front_frame;
   hcpf_pkg::frame_req_type q_head;
   logic accept, q_full, q_pop;

   // request taken whenever the frame queue has room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // header and command-code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (hcpf_pkg::cfg_index_type'(csr_index))
            hcpf_pkg::CFG_HEADER_FIRST:     cfg_ff.header_first     <= csr_wdata;
            hcpf_pkg::CFG_HEADER_SECOND:    cfg_ff.header_second    <= csr_wdata;
            hcpf_pkg::CFG_CODE_MOVE:        cfg_ff.code_move        <= csr_wdata;
            hcpf_pkg::CFG_CODE_SMOOTH_MOVE: cfg_ff.code_smooth_move <= csr_wdata;
            hcpf_pkg::CFG_CODE_BUTTONS:     cfg_ff.code_buttons     <= csr_wdata;
            hcpf_pkg::CFG_CODE_WHEEL:       cfg_ff.code_wheel       <= csr_wdata;
            hcpf_pkg::CFG_CODE_KEYBOARD:    cfg_ff.code_keyboard    <= csr_wdata;
            hcpf_pkg::CFG_CODE_RELEASE_ALL: cfg_ff.code_release_all <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: decode, saturate, update key/button state, build the frame
   hcpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .accept    (accept),
      .frame_out (front_frame)
   );

   // unknown funcs are accepted but push nothing
   hcpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && front_frame.valid),
      .push_frame (front_frame.frame),
      .full       (q_full),
      .head       (q_head),
      .pop        (q_pop)
   );

   // back: byte serialiser with running additive checksum
   hcpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .head_pop  (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ===== sim/tb_hid_command_packet_framer.sv =====
module tb_hid_command_packet_framer;
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape
   localparam int DRAIN_PAD     = 8;       // cycles past the last byte before a register write
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 30;      // 6 x 30 = 180 random known-func requests (unknown funcs extra)
   localparam int CYCLE_LIMIT   = 300000;

   // Register programming styles
   localparam int CFG_ALL_ZERO  = 0;
   localparam int CFG_ALL_ONES  = 1;
   localparam int CFG_RANDOM    = 2;

   // Receiver pop styles
   localparam int POP_ALWAYS    = 0;
   localparam int POP_LIGHT     = 1;
   localparam int POP_HEAVY     = 2;
   localparam int POP_EVERY_4TH = 3;

   // Tracks the framer's registers and HID state, and the packet bytes still owed
   class hid_frame_tracker;
      logic [7:0]        regs [8];
      logic [7:0]        key_slots [hcpf_pkg::KEY_SLOT_COUNT];
      logic [7:0]        modifiers;
      logic [7:0]        buttons;
      hcpf_pkg::rsp_type bytes_due [$];
      int                errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (key_slots[i]) key_slots[i] = '0;
         modifiers = '0;
         buttons   = '0;
         errors    = 0;
      endfunction

      function void set_register(hcpf_pkg::cfg_index_type idx, logic [7:0] value);
         regs[idx] = value;
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction

      function logic [15:0] clamp16(int v);
         if (v < -32768) return 16'h8000;
         if (v > 32767) return 16'h7FFF;
         return v[15:0];
      endfunction

      // header, header, code, length LE, body, additive sum
      function void queue_frame(logic [7:0] code, logic [7:0] body [$]);
         logic [7:0]        bytes [$];
         logic [7:0]        sum;
         logic [15:0]       len;
         hcpf_pkg::rsp_type e;
         len   = 16'(body.size());
         bytes = {regs[hcpf_pkg::CFG_HEADER_FIRST], regs[hcpf_pkg::CFG_HEADER_SECOND], code,
                  len[7:0], len[15:8]};
         foreach (body[i]) bytes = {bytes, body[i]};
         sum = '0;
         foreach (bytes[i]) sum += bytes[i];
         bytes = {bytes, sum};
         foreach (bytes[i]) begin
            e.packet_byte = bytes[i];
            e.last_byte   = (i == bytes.size() - 1);
            bytes_due     = {bytes_due, e};
         end
      endfunction

      function void note_request(hcpf_pkg::req_type r);
         logic [7:0]  body [$];
         logic [15:0] dx;
         logic [15:0] dy;
         logic [7:0]  wheel;
         int          scroll;
         bit          held;
         bit          keyboard;
         dx       = clamp16(r.delta_x);
         dy       = clamp16(r.delta_y);
         scroll   = r.scroll_amount;
         keyboard = 1'b0;
         case (hcpf_pkg::func_type'(r.func))
            hcpf_pkg::FUNC_MOVE, hcpf_pkg::FUNC_SMOOTH_MOVE: begin
               body = {dx[7:0], dx[15:8], dy[7:0], dy[15:8]};
               if (hcpf_pkg::func_type'(r.func) == hcpf_pkg::FUNC_MOVE) begin
                  queue_frame(regs[hcpf_pkg::CFG_CODE_MOVE], body);
               end else begin
                  body = {body, r.move_time[7:0], r.move_time[15:8]};
                  queue_frame(regs[hcpf_pkg::CFG_CODE_SMOOTH_MOVE], body);
               end
            end
            hcpf_pkg::FUNC_BTN_PRESS, hcpf_pkg::FUNC_BTN_RELEASE: begin
               if (hcpf_pkg::func_type'(r.func) == hcpf_pkg::FUNC_BTN_PRESS) begin
                  buttons |= r.button_bits;
               end else begin
                  buttons &= ~r.button_bits;
               end
               body = {buttons};
               queue_frame(regs[hcpf_pkg::CFG_CODE_BUTTONS], body);
            end
            hcpf_pkg::FUNC_SCROLL: begin
               if (scroll < -127) wheel = 8'h81;
               else if (scroll > 127) wheel = 8'h7F;
               else wheel = scroll[7:0];
               body = {wheel};
               queue_frame(regs[hcpf_pkg::CFG_CODE_WHEEL], body);
            end
            hcpf_pkg::FUNC_KEY_PRESS: begin
               // modifiers merge even when the table is full
               modifiers |= r.modifier_bits;
               held = 1'b0;
               foreach (key_slots[i]) if (key_slots[i] == r.key_code) held = 1'b1;
               if (!held) begin
                  for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
                     if (key_slots[i] == 8'h00) begin
                        key_slots[i] = r.key_code;
                        break;
                     end
                  end
               end
               keyboard = 1'b1;
            end
            hcpf_pkg::FUNC_KEY_RELEASE: begin
               for (int i = 0; i < hcpf_pkg::KEY_SLOT_COUNT; i++) begin
                  if (key_slots[i] == r.key_code) begin
                     key_slots[i] = 8'h00;
                     break;
                  end
               end
               keyboard = 1'b1;
            end
            hcpf_pkg::FUNC_CLEAR_MODS: begin
               modifiers &= ~r.modifier_bits;
               keyboard = 1'b1;
            end
            hcpf_pkg::FUNC_RELEASE_ALL: begin
               // buttons survive a release-all
               modifiers = '0;
               foreach (key_slots[i]) key_slots[i] = '0;
               queue_frame(regs[hcpf_pkg::CFG_CODE_RELEASE_ALL], body);
            end
            default: ;   // unknown request: silently dropped
         endcase
         if (keyboard) begin
            body = {modifiers, 8'h00};
            foreach (key_slots[i]) body = {body, key_slots[i]};
            queue_frame(regs[hcpf_pkg::CFG_CODE_KEYBOARD], body);
         end
      endfunction

      function void check_byte(hcpf_pkg::rsp_type got);
         hcpf_pkg::rsp_type want;
         if (bytes_due.size() == 0) begin
            errors++;
            $display("%0t: byte with none due: expected nothing, actual byte %h last %b",
                     $time, got.packet_byte, got.last_byte);
            return;
         end
         want = bytes_due.pop_front();
         if (got.packet_byte !== want.packet_byte) begin
            errors++;
            $display("%0t: packet_byte mismatch: expected %h, actual %h",
                     $time, want.packet_byte, got.packet_byte);
         end
         if (got.last_byte !== want.last_byte) begin
            errors++;
            $display("%0t: last_byte mismatch: expected %b, actual %b",
                     $time, want.last_byte, got.last_byte);
         end
      endfunction
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_push  = 1'b0;
   logic                            req_full;
   hcpf_pkg::req_type               req_data  = '0;
   logic                            rsp_empty;
   logic                            rsp_pop   = 1'b0;
   hcpf_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [hcpf_pkg::CFG_IDX_W-1:0]  csr_index = '0;
   logic [hcpf_pkg::CFG_DATA_W-1:0] csr_wdata = '0;

   hid_frame_tracker tracker;

   int cycle_count    = 0;
   int burst_left     = 0;
   int long_hold_asks = 0;    // bumped by the stimulus, served by the receiver
   int long_hold_seen = 0;
   int hold_left      = 0;
   int pop_mode       = POP_ALWAYS;
   int pop_cycle      = 0;

   hid_command_packet_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: checks each popped byte, then picks next cycle's pop.
   // The pop style is re-picked at random; a long hold-off overrides it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) tracker.check_byte(rsp_data);
         pop_cycle++;
         if (pop_cycle % 96 == 0) pop_mode = $urandom_range(POP_ALWAYS, POP_EVERY_4TH);
         if (long_hold_seen != long_hold_asks) begin
            long_hold_seen = long_hold_asks;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               POP_ALWAYS:  rsp_pop <= 1'b1;
               POP_LIGHT:   rsp_pop <= ($urandom_range(0, 3) != 0);
               POP_HEAVY:   rsp_pop <= ($urandom_range(0, 9) < 3);
               default:     rsp_pop <= (pop_cycle % 4 == 1);
            endcase
         end
      end
   end

   // Offer one request, in bursts separated by random gaps. Returns at the
   // edge that accepted it; push stays high so the next request can follow.
   task automatic offer(input hcpf_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      tracker.note_request(r);
   endtask

   // Sender stops until every due byte is out, then lets the pipe settle
   // in case the last request was one that frames nothing.
   task automatic wait_for_drain();
      req_push   <= 1'b0;
      burst_left  = 0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic program_registers(input int style);
      logic [7:0] value;
      for (int i = 0; i <= hcpf_pkg::CFG_CODE_RELEASE_ALL; i++) begin
         case (style)
            CFG_ALL_ZERO: value = 8'h00;
            CFG_ALL_ONES: value = 8'hFF;
            default:      value = 8'($urandom);
         endcase
         csr_we    <= 1'b1;
         csr_index <= hcpf_pkg::cfg_index_type'(i);
         csr_wdata <= value;
         @(posedge clock);
         tracker.set_register(hcpf_pkg::cfg_index_type'(i), value);
      end
      csr_we <= 1'b0;
   endtask

   function automatic hcpf_pkg::req_type base_request(input hcpf_pkg::func_type f);
      hcpf_pkg::req_type r;
      r.func          = f;
      r.delta_x       = $urandom;
      r.delta_y       = $urandom;
      r.move_time     = 16'($urandom);
      r.scroll_amount = $urandom;
      r.button_bits   = 8'($urandom);
      r.key_code      = 8'($urandom);
      r.modifier_bits = 8'($urandom);
      return r;
   endfunction

   // Values near the saturation bound, anywhere in range, small values or anything at all
   function automatic logic [31:0] pick_signed(input int bound);
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return ($urandom_range(0, 1) ? bound : -bound) + $urandom_range(0, 4) - 2;
         2:       return $urandom_range(0, 2 * bound) - bound;
         default: return $urandom_range(0, 6) - 3;
      endcase
   endfunction

   function automatic hcpf_pkg::req_type random_request();
      hcpf_pkg::req_type r;
      int                pick;
      pick            = $urandom_range(0, 99);
      r               = base_request(hcpf_pkg::FUNC_MOVE);
      r.delta_x       = pick_signed(32768);
      r.delta_y       = pick_signed(32768);
      r.scroll_amount = pick_signed(128);
      // small key pool so held keys and a full table come up often
      r.key_code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
      if (pick < 10)      r.func = hcpf_pkg::FUNC_MOVE;
      else if (pick < 20) r.func = hcpf_pkg::FUNC_SMOOTH_MOVE;
      else if (pick < 30) r.func = hcpf_pkg::FUNC_BTN_PRESS;
      else if (pick < 40) r.func = hcpf_pkg::FUNC_BTN_RELEASE;
      else if (pick < 50) r.func = hcpf_pkg::FUNC_SCROLL;
      else if (pick < 72) r.func = hcpf_pkg::FUNC_KEY_PRESS;
      else if (pick < 88) r.func = hcpf_pkg::FUNC_KEY_RELEASE;
      else if (pick < 93) r.func = hcpf_pkg::FUNC_CLEAR_MODS;
      else if (pick < 97) r.func = hcpf_pkg::FUNC_RELEASE_ALL;
      else r.func = 4'($urandom_range(int'(hcpf_pkg::FUNC_RELEASE_ALL) + 1, 15));
      return r;
   endfunction

   task automatic run_directed();
      hcpf_pkg::req_type r;
      // move saturation, both directions and full-width extremes
      r = base_request(hcpf_pkg::FUNC_MOVE);
      r.delta_x = 32'h8000_0000;
      r.delta_y = 32'h7FFF_FFFF;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_MOVE);
      r.delta_x = 32'sd32768;
      r.delta_y = -32'sd32769;
      offer(r);
      // exact 16-bit bounds, duration extremes
      r = base_request(hcpf_pkg::FUNC_SMOOTH_MOVE);
      r.delta_x   = 32'sd32767;
      r.delta_y   = -32'sd32768;
      r.move_time = 16'hFFFF;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_SMOOTH_MOVE);
      r.delta_x   = -32'sd1;
      r.delta_y   = 32'sd0;
      r.move_time = 16'h0000;
      offer(r);
      // button mask set, partial clear, full clear
      r = base_request(hcpf_pkg::FUNC_BTN_PRESS);
      r.button_bits = 8'hFF;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_BTN_RELEASE);
      r.button_bits = 8'h0F;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_BTN_RELEASE);
      r.button_bits = 8'hFF;
      offer(r);
      // wheel: in range, just under, most negative
      r = base_request(hcpf_pkg::FUNC_SCROLL);
      r.scroll_amount = 32'sd127;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_SCROLL);
      r.scroll_amount = -32'sd128;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_SCROLL);
      r.scroll_amount = 32'h8000_0000;
      offer(r);
      // new key, same key again, key code zero
      r = base_request(hcpf_pkg::FUNC_KEY_PRESS);
      r.key_code      = 8'd4;
      r.modifier_bits = 8'h81;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_KEY_PRESS);
      r.key_code      = 8'd4;
      r.modifier_bits = 8'h00;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_KEY_PRESS);
      r.key_code = 8'd0;
      offer(r);
      // fill the table; the last press finds it full
      for (int k = 5; k <= 10; k++) begin
         r = base_request(hcpf_pkg::FUNC_KEY_PRESS);
         r.key_code = 8'(k);
         offer(r);
      end
      // release of a key not held, of zero, of a held one
      r = base_request(hcpf_pkg::FUNC_KEY_RELEASE);
      r.key_code = 8'd20;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_KEY_RELEASE);
      r.key_code = 8'd0;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_KEY_RELEASE);
      r.key_code = 8'd7;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_CLEAR_MODS);
      r.modifier_bits = 8'h01;
      offer(r);
      r = base_request(hcpf_pkg::FUNC_RELEASE_ALL);
      offer(r);
      // unknown request: nothing framed
      r = base_request(hcpf_pkg::FUNC_MOVE);
      r.func = 4'hF;
      offer(r);
   endtask

   initial begin
      hcpf_pkg::req_type r;
      int                sent;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      program_registers(CFG_RANDOM);
      run_directed();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_drain();
         case (phase)
            0:       program_registers(CFG_ALL_ZERO);
            1:       program_registers(CFG_ALL_ONES);
            default: program_registers(CFG_RANDOM);
         endcase
         // long receiver hold-off while requests keep coming: fills the frame queue
         if (phase == 2) long_hold_asks <= long_hold_asks + 1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = random_request();
            offer(r);
            if (r.func <= hcpf_pkg::FUNC_RELEASE_ALL) sent++;
         end
      end

      wait_for_drain();
      if (tracker.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== hid_command_packet_framer.f =====
rtl/hcpf_pkg.sv
rtl/hcpf_front.sv
rtl/hcpf_queue.sv
rtl/hcpf_back.sv
rtl/hid_command_packet_framer.sv
sim/tb_hid_command_packet_framer.sv
